[src/wdtm_pkg.sv]
// Shared constants for the weighted distance-to-measure block.
`default_nettype none
package wdtm_pkg;

  localparam int FracBits = 16;
  localparam int DistW    = 32;
  localparam int WghtW    = 24;
  localparam int BoundW   = 32;
  localparam int TotalW   = 40;
  localparam int SumW     = 64;
  localparam int DrW      = 2 * DistW - FracBits;
  localparam int ProdW    = DrW + WghtW;
  localparam int HalfW    = 24;
  localparam int CntW     = 6;

  localparam logic [BoundW-1:0] BoundReset = BoundW'(32'h0001_0000);

  localparam logic RegWeightBound = 1'b0;
  localparam logic RegPowerMode   = 1'b1;

endpackage
`default_nettype wire

[src/weighted_distance_to_measure.sv]
// Weighted distance to measure: iterative multiply-accumulate, divide and square root.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  cfg      | cfg_we_i                 | cfg_idx_i, cfg_data_i
//  in       | in_valid_i / in_stall_o  | distance_i, neighbor_weight_i, last_in_row_i
//  out      | out_valid_o / out_stall_i| dtm_value_o, row_short_o, saturated_o
//
// One shared 32x32 multiplier does the square (r = 2) and two partial products of each item:
// an item that does not complete the row goes through square (r = 2), low product, high product, accumulate.
// The item that reaches the bound adds a 64-step restoring divide, and in r = 2 mode a
// 32-step square root; either is skipped when its result saturates.
// Reset clears the row state and loads weight_bound = 1.0, power_mode = 1; no clearing pass.
// A result waits in the output register; the input is taken again once the result is stored.
`default_nettype none
module weighted_distance_to_measure (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [wdtm_pkg::BoundW-1:0]  cfg_data_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [wdtm_pkg::DistW-1:0]   distance_i,
  input  wire logic [wdtm_pkg::WghtW-1:0]   neighbor_weight_i,
  input  wire logic                         last_in_row_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [wdtm_pkg::DistW-1:0]   dtm_value_o,
  output      logic                         row_short_o,
  output      logic                         saturated_o
);
  import wdtm_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSqr  = 4'd1;
  localparam logic [3:0] StMlo  = 4'd2;
  localparam logic [3:0] StMhi  = 4'd3;
  localparam logic [3:0] StAcc  = 4'd4;
  localparam logic [3:0] StDvSt = 4'd5;
  localparam logic [3:0] StDiv  = 4'd6;
  localparam logic [3:0] StPost = 4'd7;
  localparam logic [3:0] StRoot = 4'd8;
  localparam logic [3:0] StEmit = 4'd9;

  logic [3:0]          state_q;
  logic [BoundW-1:0]   wb_q;
  logic                pm_q;
  logic [SumW-1:0]     ms_q;
  logic [TotalW-1:0]   wt_q;
  logic                done_q;
  logic                clip_q;
  logic                out_vld_q;
  logic [DistW-1:0]    out_val_q;
  logic                out_short_q;
  logic                out_sat_q;

  logic [DrW-1:0]      dr_q;
  logic [WghtW-1:0]    weff_q;
  logic                last_q;
  logic                reach_q;
  logic [ProdW-1:0]    prod_q;
  logic [SumW-1:0]     qt_q;
  logic [BoundW-1:0]   rem_q;
  logic [SumW-1:0]     res_q;
  logic [SumW-1:0]     bit_q;
  logic [DistW-1:0]    val_q;
  logic                short_q;
  logic                rclip_q;
  logic [CntW-1:0]     cnt_q;

  logic [BoundW-1:0]   bnd;
  logic [TotalW:0]     sum_w;
  logic [TotalW-1:0]   miss_w;
  logic                at_bound;
  logic                cross_bound;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         mul_p;
  logic                clip_t;
  logic [SumW-1:0]     term;
  logic [SumW:0]       sum_ms;
  logic [SumW-1:0]     ms_new;
  logic                clip_new;
  logic [BoundW:0]     rem_sh;
  logic                div_ge;
  logic [SumW-1:0]     root_rb;
  logic                root_ge;
  logic [SumW-1:0]     res_nx;
  logic                out_free;
  logic                accept;

  assign bnd         = (wb_q == '0) ? BoundW'(1) : wb_q;
  assign sum_w       = {1'b0, wt_q} + (TotalW + 1)'(neighbor_weight_i);
  assign miss_w      = TotalW'(bnd) - wt_q;
  assign at_bound    = wt_q >= TotalW'(bnd);
  assign cross_bound = sum_w >= (TotalW + 1)'(bnd);

  always_comb begin
    case (state_q)
      StSqr: begin
        mul_a = dr_q[DistW-1:0];
        mul_b = dr_q[DistW-1:0];
      end
      StMlo: begin
        mul_a = 32'(dr_q[HalfW-1:0]);
        mul_b = 32'(weff_q);
      end
      StMhi: begin
        mul_a = 32'(dr_q[DrW-1:HalfW]);
        mul_b = 32'(weff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign clip_t   = |prod_q[ProdW-1:SumW];
  assign term     = (clip_t || (&prod_q[SumW-1:0])) ? {SumW{1'b1}}
                                                   : SumW'(prod_q[SumW-1:FracBits]);
  assign sum_ms   = {1'b0, ms_q} + {1'b0, term};
  assign ms_new   = sum_ms[SumW] ? {SumW{1'b1}} : sum_ms[SumW-1:0];
  assign clip_new = clip_q | clip_t | sum_ms[SumW];

  assign rem_sh = {rem_q, qt_q[SumW-1]};
  assign div_ge = rem_sh >= (BoundW + 1)'(bnd);

  assign root_rb = res_q + bit_q;
  assign root_ge = qt_q >= root_rb;
  assign res_nx  = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  assign out_free   = !out_vld_q || !out_stall_i;
  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = state_q != StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wb_q        <= BoundReset;
      pm_q        <= 1'b1;
      ms_q        <= '0;
      wt_q        <= '0;
      done_q      <= 1'b0;
      clip_q      <= 1'b0;
      out_vld_q   <= 1'b0;
      out_val_q   <= '0;
      out_short_q <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWeightBound: wb_q <= cfg_data_i;
          RegPowerMode:   pm_q <= cfg_data_i[0];
          default:        ;
        endcase
      end
      if (out_vld_q && !out_stall_i && (state_q != StEmit)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (done_q) begin
              if (last_in_row_i) begin
                ms_q   <= '0;
                wt_q   <= '0;
                done_q <= 1'b0;
                clip_q <= 1'b0;
              end
            end else begin
              wt_q    <= sum_w[TotalW-1:0];
              state_q <= pm_q ? StSqr : StMlo;
            end
          end
        end
        StSqr:  state_q <= StMlo;
        StMlo:  state_q <= StMhi;
        StMhi:  state_q <= StAcc;
        StAcc: begin
          ms_q   <= ms_new;
          clip_q <= clip_new;
          if (reach_q) begin
            state_q <= StDvSt;
          end else if (last_q) begin
            state_q <= StEmit;
          end else begin
            state_q <= StIdle;
          end
        end
        StDvSt: begin
          if (BoundW'(ms_q[SumW-1:SumW-FracBits]) >= bnd) begin
            state_q <= StPost;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (cnt_q == CntW'(SumW - 1)) begin
            state_q <= StPost;
          end
        end
        StPost: begin
          if (!pm_q || (|qt_q[SumW-1:SumW-FracBits])) begin
            state_q <= StEmit;
          end else begin
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (cnt_q == CntW'(SumW / 2 - 1)) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_val_q   <= val_q;
            out_short_q <= short_q;
            out_sat_q   <= rclip_q;
            if (last_q) begin
              ms_q   <= '0;
              wt_q   <= '0;
              done_q <= 1'b0;
              clip_q <= 1'b0;
            end else begin
              done_q <= 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept && !done_q) begin
          dr_q    <= DrW'(distance_i);
          last_q  <= last_in_row_i;
          reach_q <= at_bound || cross_bound;
          if (at_bound) begin
            weff_q <= '0;
          end else if (cross_bound) begin
            weff_q <= miss_w[WghtW-1:0];
          end else begin
            weff_q <= neighbor_weight_i;
          end
        end
      end
      StSqr: dr_q <= mul_p[2*DistW-1:FracBits];
      StMlo: prod_q <= ProdW'(mul_p);
      StMhi: prod_q <= prod_q + {mul_p[ProdW-HalfW-1:0], {HalfW{1'b0}}};
      StAcc: begin
        rclip_q <= clip_new;
        short_q <= !reach_q;
        val_q   <= '0;
      end
      StDvSt: begin
        cnt_q <= '0;
        if (BoundW'(ms_q[SumW-1:SumW-FracBits]) >= bnd) begin
          qt_q    <= {SumW{1'b1}};
          rclip_q <= 1'b1;
        end else begin
          rem_q <= BoundW'(ms_q[SumW-1:SumW-FracBits]);
          qt_q  <= {ms_q[SumW-FracBits-1:0], {FracBits{1'b0}}};
        end
      end
      StDiv: begin
        rem_q <= div_ge ? BoundW'(rem_sh - (BoundW + 1)'(bnd)) : rem_sh[BoundW-1:0];
        qt_q  <= {qt_q[SumW-2:0], div_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      StPost: begin
        if (!pm_q) begin
          if (|qt_q[SumW-1:DistW]) begin
            val_q   <= {DistW{1'b1}};
            rclip_q <= 1'b1;
          end else begin
            val_q <= qt_q[DistW-1:0];
          end
        end else if (|qt_q[SumW-1:SumW-FracBits]) begin
          val_q   <= {DistW{1'b1}};
          rclip_q <= 1'b1;
        end else begin
          qt_q  <= {qt_q[SumW-FracBits-1:0], {FracBits{1'b0}}};
          res_q <= '0;
          bit_q <= SumW'(1) << (SumW - 2);
          cnt_q <= '0;
        end
      end
      StRoot: begin
        if (root_ge) begin
          qt_q <= qt_q - root_rb;
        end
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + CntW'(1);
        val_q <= res_nx[DistW-1:0];
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign dtm_value_o = out_val_q;
  assign row_short_o = out_short_q;
  assign saturated_o = out_sat_q;

endmodule
`default_nettype wire

[tb/tb_weighted_distance_to_measure.sv]
// Self-checking bench for weighted_distance_to_measure with a bit-true DTM predictor.
module tb_weighted_distance_to_measure;
  import wdtm_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int SettleCycles = 200;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [23:0] MaxWght = 24'hFF_FFFF;

  typedef struct packed {
    logic [DistW-1:0] dval;
    logic [WghtW-1:0] wght;
    logic             last;
  } neighbor_t;

  typedef struct packed {
    logic [DistW-1:0] dtm;
    logic             row_short;
    logic             sat;
  } dtm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [BoundW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [DistW-1:0] distance_i = '0;
  logic [WghtW-1:0] neighbor_weight_i = '0;
  logic last_in_row_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DistW-1:0] dtm_value_o;
  logic row_short_o;
  logic saturated_o;

  weighted_distance_to_measure dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .distance_i        (distance_i),
    .neighbor_weight_i (neighbor_weight_i),
    .last_in_row_i     (last_in_row_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .dtm_value_o       (dtm_value_o),
    .row_short_o       (row_short_o),
    .saturated_o       (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  neighbor_t   neighbor_q[$];
  dtm_result_t grid_dtm_q[$];
  int          queued_neighbors = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // predictor copy of registers and row state
  logic [31:0] bound_reg = BoundReset;
  logic        power_reg = 1'b1;
  logic [63:0] moment_acc = '0;
  logic [39:0] weight_acc = '0;
  logic        row_closed = 1'b0;
  logic        clip_flag = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] probe;
    logic [63:0] rem;
    root = '0;
    rem = x;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic reset_row();
    moment_acc = '0;
    weight_acc = '0;
    row_closed = 1'b0;
    clip_flag = 1'b0;
  endtask

  task automatic accumulate_neighbor(input logic [31:0] d, input logic [23:0] w, input logic last);
    logic [63:0] bnd;
    logic [63:0] weff;
    logic [63:0] dr;
    logic [63:0] term;
    logic [127:0] prod;
    logic [64:0] sum_ext;
    logic [95:0] quot;
    logic [63:0] q;
    logic [63:0] val;
    logic reached;
    logic clip;
    dtm_result_t res;
    bnd = (bound_reg == 0) ? 64'd1 : {32'd0, bound_reg};
    if (row_closed) begin
      if (last) reset_row();
    end else begin
      weff = {40'd0, w};
      reached = 1'b0;
      if ({24'd0, weight_acc} >= bnd) begin
        weff = '0;
        reached = 1'b1;
      end else if ({24'd0, weight_acc} + {40'd0, w} >= bnd) begin
        weff = bnd - {24'd0, weight_acc};
        reached = 1'b1;
      end
      weight_acc = weight_acc + {16'd0, w};
      dr = power_reg ? (({32'd0, d} * {32'd0, d}) >> FracBits) : {32'd0, d};
      prod = {64'd0, dr} * {64'd0, weff};
      if (prod[127:64] != 0) begin
        term = '1;
        clip_flag = 1'b1;
      end else if (prod[63:0] == '1) begin
        term = '1;
      end else begin
        term = prod[63:0] >> FracBits;
      end
      sum_ext = {1'b0, moment_acc} + {1'b0, term};
      if (sum_ext[64]) begin
        moment_acc = '1;
        clip_flag = 1'b1;
      end else begin
        moment_acc = sum_ext[63:0];
      end
      if (reached) begin
        clip = clip_flag;
        quot = ({32'd0, moment_acc} << FracBits) / {32'd0, bnd};
        if (quot[95:64] != 0) begin
          q = '1;
          clip = 1'b1;
        end else begin
          q = quot[63:0];
        end
        if (power_reg) begin
          if (q > (64'hFFFF_FFFF_FFFF_FFFF >> FracBits)) begin
            val = {32'd0, Max32};
            clip = 1'b1;
          end else begin
            val = int_sqrt(q << FracBits);
            if (val > {32'd0, Max32}) begin
              val = {32'd0, Max32};
              clip = 1'b1;
            end
          end
        end else if (q > {32'd0, Max32}) begin
          val = {32'd0, Max32};
          clip = 1'b1;
        end else begin
          val = q;
        end
        res.dtm = val[31:0];
        res.row_short = 1'b0;
        res.sat = clip;
        grid_dtm_q.push_back(res);
        if (last) reset_row();
        else row_closed = 1'b1;
      end else if (last) begin
        res.dtm = '0;
        res.row_short = 1'b1;
        res.sat = clip_flag;
        grid_dtm_q.push_back(res);
        reset_row();
      end
    end
  endtask

  // sender: bursts and gaps, hold payload while stalled
  neighbor_t next_nb;
  int idle_left;
  int burst_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left = 0;
      burst_left = 0;
    end else begin
      if (in_valid_i && in_stall_o === 1'b0)
        accumulate_neighbor(distance_i, neighbor_weight_i, last_in_row_i);
      if (!in_valid_i || in_stall_o === 1'b0) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (neighbor_q.size() > 0) begin
          next_nb = neighbor_q.pop_front();
          in_valid_i <= 1'b1;
          distance_i <= next_nb.dval;
          neighbor_weight_i <= next_nb.wght;
          last_in_row_i <= next_nb.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(30, 1);
            idle_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall density changes per segment
  int stall_seg_left;
  int stall_pct;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_seg_left = 0;
      stall_pct = 0;
    end else begin
      if (stall_seg_left == 0) begin
        stall_seg_left = $urandom_range(300, 10);
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      stall_seg_left--;
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  dtm_result_t got_res;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (grid_dtm_q.size() == 0) begin
        $display("%0t: unexpected transfer dtm_value %h row_short %b saturated %b",
                 $time, dtm_value_o, row_short_o, saturated_o);
        mismatch_count++;
      end else begin
        got_res = grid_dtm_q.pop_front();
        if (dtm_value_o !== got_res.dtm) begin
          $display("%0t: dtm_value expected %h actual %h", $time, got_res.dtm, dtm_value_o);
          mismatch_count++;
        end
        if (row_short_o !== got_res.row_short) begin
          $display("%0t: row_short expected %b actual %b", $time, got_res.row_short,
                   row_short_o);
          mismatch_count++;
        end
        if (saturated_o !== got_res.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, got_res.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_neighbor(input logic [31:0] d, input logic [23:0] w, input logic last);
    neighbor_t nb;
    nb.dval = d;
    nb.wght = w;
    nb.last = last;
    neighbor_q.push_back(nb);
    queued_neighbors++;
  endtask

  task automatic queue_row(input logic [31:0] bound_cfg);
    logic [63:0] bnd;
    logic [63:0] avg;
    logic [63:0] hi_w;
    logic [63:0] dl;
    logic [31:0] d;
    logic [31:0] step;
    logic [23:0] w;
    int k;
    int n;
    int style;
    int dsel;
    bnd = (bound_cfg == 0) ? 64'd1 : {32'd0, bound_cfg};
    k = $urandom_range(6, 1);
    avg = (bnd + k - 1) / k;
    if (avg > {40'd0, MaxWght}) avg = {40'd0, MaxWght};
    n = int'((bnd + avg - 1) / avg) + $urandom_range(3, 0);
    hi_w = avg + avg / 2;
    if (hi_w > {40'd0, MaxWght}) hi_w = {40'd0, MaxWght};
    style = $urandom_range(99, 0);
    dsel = $urandom_range(9, 0);
    if (dsel < 6) begin
      d = $urandom_range(32'h0010_0000, 0);
      step = 32'h0002_0000;
    end else if (dsel < 9) begin
      d = $urandom;
      step = 32'h0100_0000;
    end else begin
      d = Max32 - $urandom_range(32'h0001_0000, 0);
      step = 32'h0000_4000;
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        dl = {32'd0, d} + $urandom_range(step, 0);
        d = (dl > {32'd0, Max32}) ? Max32 : dl[31:0];
      end
      if (style < 75) begin
        w = 24'($urandom_range(hi_w[31:0], avg[31:0] / 2));
      end else if (style < 85) begin
        w = ($urandom_range(3, 0) == 0) ? 24'd0 : 24'($urandom_range(MaxWght, 0));
      end else if (style < 92) begin
        d = $urandom;
        w = 24'($urandom_range(hi_w[31:0], avg[31:0] / 2));
      end else begin
        w = 24'($urandom_range(avg[31:0] / 4, 0));
      end
      queue_neighbor(d, w, i == n - 1);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWeightBound) bound_reg = data;
    else power_reg = data[0];
  endtask

  task automatic set_config(input logic [31:0] bound_cfg, input logic mode);
    write_reg(RegWeightBound, bound_cfg);
    write_reg(RegPowerMode, ($urandom & ~32'd1) | {31'd0, mode});
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (neighbor_q.size() != 0 || in_valid_i || grid_dtm_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  logic [31:0] phase_bound[8];
  logic        phase_mode[8];
  int          phase_budget[8];
  int          phase_start;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: bound 1.0, power 2
    queue_neighbor(32'h0001_0000, 24'h00_8000, 1'b0);
    queue_neighbor(32'h0002_0000, 24'h00_8000, 1'b1);
    queue_neighbor(32'h0000_0000, 24'h00_0000, 1'b0);
    queue_neighbor(32'h0000_8000, 24'h01_0000, 1'b0);
    queue_neighbor(32'h0001_0000, 24'h01_0000, 1'b0);
    queue_neighbor(32'h0003_0000, 24'h01_0000, 1'b1);
    queue_neighbor(32'h0001_0000, 24'h00_4000, 1'b1);
    queue_neighbor(Max32, MaxWght, 1'b1);
    queue_neighbor(32'h0003_0000, 24'h00_4CCD, 1'b0);
    queue_neighbor(32'h0001_0000, 24'h00_4CCD, 1'b0);
    queue_neighbor(32'h0000_0000, MaxWght, 1'b1);
    queue_neighbor(32'h0000_0000, 24'h00_0000, 1'b1);
    drain();

    // zero bound acts as the smallest bound
    set_config(32'd0, 1'b0);
    queue_neighbor(32'h0005_0000, 24'h00_0000, 1'b0);
    queue_neighbor(32'h0007_0000, 24'h00_0001, 1'b1);
    queue_neighbor(Max32, 24'h00_0001, 1'b1);
    drain();

    // largest bound: short saturated row, then leave a row open
    set_config(Max32, 1'b1);
    queue_neighbor(Max32, MaxWght, 1'b0);
    queue_neighbor(Max32, MaxWght, 1'b0);
    queue_neighbor(Max32, MaxWght, 1'b1);
    queue_neighbor(32'h0002_0000, 24'h00_C000, 1'b0);
    drain();

    // lower the bound below the open row's total
    set_config(32'h0000_8000, 1'b1);
    queue_neighbor(32'h0001_0000, 24'h00_0000, 1'b1);
    queue_neighbor(32'h0000_4000, 24'h00_8000, 1'b1);
    queue_neighbor(32'h0001_0000, 24'h00_8000, 1'b1);
    drain();

    phase_bound = '{32'h0001_0000, 32'h0001_0000, 32'd0, 32'd1,
                    $urandom_range(32'h0000_FFFF, 2),
                    $urandom_range(32'h0040_0000, 32'h0001_0000),
                    $urandom_range(32'h1000_0000, 32'h0040_0000), Max32};
    phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_budget = '{250, 250, 100, 100, 150, 250, 250, 500};

    for (int p = 0; p < 8; p++) begin
      set_config(phase_bound[p], phase_mode[p]);
      phase_start = queued_neighbors;
      while (queued_neighbors - phase_start < phase_budget[p]) queue_row(phase_bound[p]);
      drain();
    end

    if (mismatch_count == 0 && grid_dtm_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
